### hw/rtl/tste_pkg.sv
// shared types and constants of the two-set table engine
package tste_pkg;

	// defaults for the top-level parameters
	localparam int DEPTH_DEF      = 16;
	localparam int ELEM_WIDTH_DEF = 32;

	// fixed widths of the channel fields
	localparam int REQ_W   = 3;
	localparam int VALUE_W = 32;
	localparam int COUNT_W = 5;

	// request codes
	typedef enum logic [REQ_W-1:0] {
		REQ_INSERT  = 3'd0,
		REQ_REMOVE  = 3'd1,
		REQ_UNION   = 3'd2,
		REQ_INTER   = 3'd3,
		REQ_DIFF    = 3'd4,
		REQ_COMPARE = 3'd5
	} req_code_t;

	// sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_LOOKUP,
		S_OUTER,
		S_INNER,
		S_KEEP,
		S_REPLY
	} state_t;

endpackage

### hw/rtl/tste_req_if.sv
// request channel of the two-set table engine
interface tste_req_if;
	import tste_pkg::*;

	logic                      valid;
	logic                      ready;
	logic [REQ_W-1:0]          req_type;
	logic                      which_set;
	logic signed [VALUE_W-1:0] value;

	modport source (output valid, req_type, which_set, value, input ready);
	modport sink (input valid, req_type, which_set, value, output ready);
endinterface

### hw/rtl/tste_rsp_if.sv
// result channel of the two-set table engine
interface tste_rsp_if;
	import tste_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [VALUE_W-1:0] elem_value;
	logic                      last;
	logic                      run_empty;
	logic                      a_in_b;
	logic                      b_in_a;
	logic                      sets_equal;
	logic                      rejected_full;
	logic [COUNT_W-1:0]        count_after;

	modport source (output valid, elem_value, last, run_empty, a_in_b, b_in_a, sets_equal,
		rejected_full, count_after, input ready);
	modport sink (input valid, elem_value, last, run_empty, a_in_b, b_in_a, sets_equal,
		rejected_full, count_after, output ready);
endinterface

### hw/rtl/two_set_table_engine.sv
// two-set table engine: two insertion-ordered sets with insert, remove and set operations
//
// Requests arrive on the req channel (valid/ready, one transfer per request); results
// leave on the rsp channel, one transfer per result item, the final one marked by last.
// Insert and remove give one item with count_after (and rejected_full for a dropped
// insert). Union, intersection and difference stream their elements in order, or one
// item with run_empty when the result holds none. Compare gives one item with the subset
// and equality flags. Request codes 6 and 7 are taken and dropped without a result.
// One equality comparator is shared by every scan, so the time a request takes grows with
// the set sizes: insert or remove scans one set, intersection and difference scan B for
// each element of A, and union and compare also scan A for each element of B.
// A new request is taken only once the sequencer is back in idle.
// The result register holds one item; while the receiver stalls it holds, and the
// sequencer waits whenever it has a further item to hand over.
// Reset (arst_n low) empties both sets and drops any result in flight; entry storage is
// not cleared, only entries below the count are ever read.
module two_set_table_engine #(
	parameter int DEPTH      = tste_pkg::DEPTH_DEF,
	parameter int ELEM_WIDTH = tste_pkg::ELEM_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	tste_req_if.sink    req,
	tste_rsp_if.source  rsp
);
	import tste_pkg::*;

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	// set storage and counts
	logic [ELEM_WIDTH-1:0] set_a_q [DEPTH];
	logic [ELEM_WIDTH-1:0] set_b_q [DEPTH];
	logic [CNT_W-1:0]      cnt_a_q, cnt_b_q;

	// sequencer registers
	state_t                state_q, state_d;
	req_code_t             req_q;
	logic                  sel_q;
	logic [ELEM_WIDTH-1:0] val_q;
	logic [CNT_W-1:0]      i_q, j_q;
	logic                  phase_q;
	logic                  found_q;
	logic                  ab_q, ba_q;
	logic                  rej_q;
	logic [ELEM_WIDTH-1:0] pend_q;
	logic                  pend_valid_q;

	// result register
	logic                      out_valid_q;
	logic signed [VALUE_W-1:0] out_elem_q;
	logic                      out_last_q, out_empty_q, out_ab_q, out_ba_q, out_eq_q, out_rej_q;
	logic [COUNT_W-1:0]        out_cnt_q;

	// datapath signals
	logic [CNT_W-1:0]      cur_cnt, x_cnt, y_cnt, scan_cnt;
	logic [IDX_W-1:0]      addr_a, addr_b;
	logic [ELEM_WIDTH-1:0] rd_a, rd_b, x_elem, y_elem, cmp_x, cmp_y;
	logic                  cmp_eq, j_live, hit;
	logic [2*VALUE_W-1:0]  val_sx;
	logic [ELEM_WIDTH+VALUE_W-1:0] pend_ext;
	logic [CNT_W+COUNT_W-1:0]      cnt_ext;

	// control signals
	logic accept, slot_free, keep, keep_stall, emit_pend, emit_reply;
	logic outer_end, phase_more, lookup_done, inner_done;
	logic                      out_last_d, out_empty_d, out_ab_d, out_ba_d, out_eq_d, out_rej_d;
	logic signed [VALUE_W-1:0] out_elem_d;
	logic [COUNT_W-1:0]        out_cnt_d;

	// read ports and the shared comparator
	always_comb begin
		cur_cnt = sel_q ? cnt_b_q : cnt_a_q;
		x_cnt   = phase_q ? cnt_b_q : cnt_a_q;
		y_cnt   = phase_q ? cnt_a_q : cnt_b_q;
		if (state_q == S_LOOKUP) begin
			addr_a   = j_q[IDX_W-1:0];
			addr_b   = j_q[IDX_W-1:0];
			scan_cnt = cur_cnt;
		end else if (!phase_q) begin
			addr_a   = i_q[IDX_W-1:0];
			addr_b   = j_q[IDX_W-1:0];
			scan_cnt = y_cnt;
		end else begin
			addr_a   = j_q[IDX_W-1:0];
			addr_b   = i_q[IDX_W-1:0];
			scan_cnt = y_cnt;
		end
		rd_a   = set_a_q[addr_a];
		rd_b   = set_b_q[addr_b];
		x_elem = phase_q ? rd_b : rd_a;
		y_elem = phase_q ? rd_a : rd_b;
		cmp_x  = (state_q == S_LOOKUP) ? val_q : x_elem;
		cmp_y  = (state_q == S_LOOKUP) ? (sel_q ? rd_b : rd_a) : y_elem;
		cmp_eq = (cmp_x == cmp_y);
		j_live = (j_q < scan_cnt);
		hit    = j_live && cmp_eq;
	end

	// value widening and narrowing to and from the element width
	assign val_sx   = {{VALUE_W{req.value[VALUE_W-1]}}, req.value};
	assign pend_ext = {{VALUE_W{1'b0}}, pend_q};
	assign cnt_ext  = {{COUNT_W{1'b0}}, cur_cnt};

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					if (req.req_type inside {REQ_INSERT, REQ_REMOVE})
						state_d = S_LOOKUP;
					else if (req.req_type inside {REQ_UNION, REQ_INTER, REQ_DIFF, REQ_COMPARE})
						state_d = S_OUTER;
				end
			end
			S_LOOKUP: begin
				if (lookup_done)
					state_d = S_REPLY;
			end
			S_OUTER: begin
				if (!outer_end)
					state_d = S_INNER;
				else if (!phase_more)
					state_d = S_REPLY;
			end
			S_INNER: begin
				if (inner_done)
					state_d = S_KEEP;
			end
			S_KEEP: begin
				if (!keep_stall)
					state_d = S_OUTER;
			end
			S_REPLY: begin
				if (slot_free)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// sequencer outputs and the result item being built
	always_comb begin
		req.ready   = (state_q == S_IDLE);
		accept      = req.valid && req.ready;
		slot_free   = !out_valid_q || rsp.ready;
		lookup_done = (state_q == S_LOOKUP) && (!j_live || cmp_eq);
		inner_done  = !j_live || cmp_eq;
		outer_end   = (i_q == x_cnt);
		phase_more  = !phase_q && (req_q == REQ_UNION || req_q == REQ_COMPARE);
		case (req_q)
			REQ_UNION: keep = !phase_q || !found_q;
			REQ_INTER: keep = found_q;
			REQ_DIFF:  keep = !found_q;
			default:   keep = 1'b0;
		endcase
		keep_stall = keep && pend_valid_q && !slot_free;
		emit_pend  = (state_q == S_KEEP) && keep && pend_valid_q && slot_free;
		emit_reply = (state_q == S_REPLY) && slot_free;

		out_elem_d  = '0;
		out_last_d  = 1'b0;
		out_empty_d = 1'b0;
		out_ab_d    = 1'b0;
		out_ba_d    = 1'b0;
		out_eq_d    = 1'b0;
		out_rej_d   = 1'b0;
		out_cnt_d   = '0;
		if (emit_pend) begin
			out_elem_d = pend_ext[VALUE_W-1:0];
		end else begin
			out_last_d = 1'b1;
			case (req_q)
				REQ_INSERT, REQ_REMOVE: begin
					out_rej_d = rej_q;
					out_cnt_d = cnt_ext[COUNT_W-1:0];
				end
				REQ_COMPARE: begin
					out_ab_d = ab_q;
					out_ba_d = ba_q;
					out_eq_d = ab_q && ba_q;
				end
				default: begin
					if (pend_valid_q)
						out_elem_d = pend_ext[VALUE_W-1:0];
					else
						out_empty_d = 1'b1;
				end
			endcase
		end
	end

	// entry storage: append on insert, close the gap on remove
	always_ff @(posedge clk) begin
		if (state_q == S_LOOKUP && !j_live && req_q == REQ_INSERT &&
				cur_cnt != CNT_W'(DEPTH)) begin
			if (sel_q)
				set_b_q[cur_cnt[IDX_W-1:0]] <= val_q;
			else
				set_a_q[cur_cnt[IDX_W-1:0]] <= val_q;
		end
		if (state_q == S_LOOKUP && hit && req_q == REQ_REMOVE) begin
			for (int k = 0; k < DEPTH - 1; k++) begin
				if (CNT_W'(k) >= j_q) begin
					if (sel_q)
						set_b_q[k] <= set_b_q[k+1];
					else
						set_a_q[k] <= set_a_q[k+1];
				end
			end
		end
	end

	// sequencer and counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cnt_a_q      <= '0;
			cnt_b_q      <= '0;
			req_q        <= REQ_INSERT;
			sel_q        <= 1'b0;
			val_q        <= '0;
			i_q          <= '0;
			j_q          <= '0;
			phase_q      <= 1'b0;
			found_q      <= 1'b0;
			ab_q         <= 1'b1;
			ba_q         <= 1'b1;
			rej_q        <= 1'b0;
			pend_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						req_q        <= req_code_t'(req.req_type);
						sel_q        <= req.which_set;
						val_q        <= val_sx[ELEM_WIDTH-1:0];
						i_q          <= '0;
						j_q          <= '0;
						phase_q      <= 1'b0;
						ab_q         <= 1'b1;
						ba_q         <= 1'b1;
						rej_q        <= 1'b0;
						pend_valid_q <= 1'b0;
					end
				end
				S_LOOKUP: begin
					if (hit) begin
						if (req_q == REQ_REMOVE) begin
							if (sel_q)
								cnt_b_q <= cnt_b_q - 1'b1;
							else
								cnt_a_q <= cnt_a_q - 1'b1;
						end
					end else if (!j_live) begin
						if (req_q == REQ_INSERT) begin
							if (cur_cnt == CNT_W'(DEPTH))
								rej_q <= 1'b1;
							else if (sel_q)
								cnt_b_q <= cnt_b_q + 1'b1;
							else
								cnt_a_q <= cnt_a_q + 1'b1;
						end
					end else begin
						j_q <= j_q + 1'b1;
					end
				end
				S_OUTER: begin
					j_q <= '0;
					if (outer_end && phase_more) begin
						phase_q <= 1'b1;
						i_q     <= '0;
					end
				end
				S_INNER: begin
					if (inner_done)
						found_q <= hit;
					else
						j_q <= j_q + 1'b1;
				end
				S_KEEP: begin
					if (!keep_stall) begin
						i_q <= i_q + 1'b1;
						if (keep)
							pend_valid_q <= 1'b1;
						if (req_q == REQ_COMPARE && !found_q) begin
							if (phase_q)
								ba_q <= 1'b0;
							else
								ab_q <= 1'b0;
						end
					end
				end
				S_REPLY: begin
					if (slot_free)
						pend_valid_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	// pending element held back until it is known whether it is the last
	always_ff @(posedge clk) begin
		if (state_q == S_KEEP && keep && !keep_stall)
			pend_q <= x_elem;
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_pend || emit_reply) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (emit_pend || emit_reply) begin
			out_elem_q  <= out_elem_d;
			out_last_q  <= out_last_d;
			out_empty_q <= out_empty_d;
			out_ab_q    <= out_ab_d;
			out_ba_q    <= out_ba_d;
			out_eq_q    <= out_eq_d;
			out_rej_q   <= out_rej_d;
			out_cnt_q   <= out_cnt_d;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.elem_value    = out_elem_q;
	assign rsp.last          = out_last_q;
	assign rsp.run_empty     = out_empty_q;
	assign rsp.a_in_b        = out_ab_q;
	assign rsp.b_in_a        = out_ba_q;
	assign rsp.sets_equal    = out_eq_q;
	assign rsp.rejected_full = out_rej_q;
	assign rsp.count_after   = out_cnt_q;

	// counts never pass the capacity
	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_a_q <= CNT_W'(DEPTH)) && (cnt_b_q <= CNT_W'(DEPTH)))
		else $error("set count beyond capacity");

	// a rejected insert only ever happens on a full set
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_REPLY && rej_q) |-> (cur_cnt == CNT_W'(DEPTH)))
		else $error("insert rejected on a set that is not full");

	// only union, intersection and difference hold back an element
	assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_q |-> (req_q == REQ_UNION || req_q == REQ_INTER || req_q == REQ_DIFF))
		else $error("pending element outside a set operation");

	// a new request is never taken while an element is still held back
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_REPLY && slot_free) |=> !pend_valid_q)
		else $error("pending element left over after the final result");

endmodule
